@@ rtl/sca_pkg.sv @@
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types, key codes and character ROMs for the scan code to ASCII FIFO.
// ----------------------------------------------------------------------------
package sca_pkg;

  localparam int unsigned CHAR_W = 7;

  // Per-item operations
  typedef enum logic [1:0] {
    ACT_SCAN  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Set 1 key codes of the modifier keys
  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_CTRL   = 7'h1D;
  localparam logic [6:0] KEY_ALT    = 7'h38;

  // Ctrl folds lowercase letters down to 1..26
  localparam logic [CHAR_W-1:0] CTRL_OFFSET = 7'h60;
  localparam logic [CHAR_W-1:0] LOWER_A     = 7'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z     = 7'h7A;

  // Decoded view of one scan byte
  typedef struct packed {
    logic              shift_we;
    logic              ctrl_we;
    logic              held;
    logic              push;
    logic [CHAR_W-1:0] key_char;
  } key_t;

  // US layout, no shift
  function automatic logic [CHAR_W-1:0] rom_plain(input logic [6:0] code);
    logic [CHAR_W-1:0] c;
    unique case (code)
      7'd1:    c = 7'h1B;  // escape
      7'd2:    c = 7'h31;
      7'd3:    c = 7'h32;
      7'd4:    c = 7'h33;
      7'd5:    c = 7'h34;
      7'd6:    c = 7'h35;
      7'd7:    c = 7'h36;
      7'd8:    c = 7'h37;
      7'd9:    c = 7'h38;
      7'd10:   c = 7'h39;
      7'd11:   c = 7'h30;
      7'd12:   c = 7'h2D;  // -
      7'd13:   c = 7'h3D;  // =
      7'd14:   c = 7'h08;  // backspace
      7'd15:   c = 7'h09;  // tab
      7'd16:   c = 7'h71;  // q
      7'd17:   c = 7'h77;
      7'd18:   c = 7'h65;
      7'd19:   c = 7'h72;
      7'd20:   c = 7'h74;
      7'd21:   c = 7'h79;
      7'd22:   c = 7'h75;
      7'd23:   c = 7'h69;
      7'd24:   c = 7'h6F;
      7'd25:   c = 7'h70;
      7'd26:   c = 7'h5B;  // [
      7'd27:   c = 7'h5D;  // ]
      7'd28:   c = 7'h0A;  // enter
      7'd30:   c = 7'h61;  // a
      7'd31:   c = 7'h73;
      7'd32:   c = 7'h64;
      7'd33:   c = 7'h66;
      7'd34:   c = 7'h67;
      7'd35:   c = 7'h68;
      7'd36:   c = 7'h6A;
      7'd37:   c = 7'h6B;
      7'd38:   c = 7'h6C;
      7'd39:   c = 7'h3B;  // ;
      7'd40:   c = 7'h27;  // quote
      7'd41:   c = 7'h60;  // backtick
      7'd43:   c = 7'h5C;  // backslash
      7'd44:   c = 7'h7A;  // z
      7'd45:   c = 7'h78;
      7'd46:   c = 7'h63;
      7'd47:   c = 7'h76;
      7'd48:   c = 7'h62;
      7'd49:   c = 7'h6E;
      7'd50:   c = 7'h6D;
      7'd51:   c = 7'h2C;  // ,
      7'd52:   c = 7'h2E;  // .
      7'd53:   c = 7'h2F;  // /
      7'd55:   c = 7'h2A;  // *
      7'd57:   c = 7'h20;  // space
      7'd74:   c = 7'h2D;  // keypad minus
      7'd78:   c = 7'h2B;  // keypad plus
      default: c = '0;
    endcase
    return c;
  endfunction

  // US layout, shift held
  function automatic logic [CHAR_W-1:0] rom_shift(input logic [6:0] code);
    logic [CHAR_W-1:0] c;
    unique case (code)
      7'd1:    c = 7'h1B;
      7'd2:    c = 7'h21;  // !
      7'd3:    c = 7'h40;  // @
      7'd4:    c = 7'h23;  // #
      7'd5:    c = 7'h24;  // $
      7'd6:    c = 7'h25;  // %
      7'd7:    c = 7'h5E;  // ^
      7'd8:    c = 7'h26;  // &
      7'd9:    c = 7'h2A;  // *
      7'd10:   c = 7'h28;  // (
      7'd11:   c = 7'h29;  // )
      7'd12:   c = 7'h5F;  // _
      7'd13:   c = 7'h2B;  // +
      7'd14:   c = 7'h08;
      7'd15:   c = 7'h09;
      7'd16:   c = 7'h51;  // Q
      7'd17:   c = 7'h57;
      7'd18:   c = 7'h45;
      7'd19:   c = 7'h52;
      7'd20:   c = 7'h54;
      7'd21:   c = 7'h59;
      7'd22:   c = 7'h55;
      7'd23:   c = 7'h49;
      7'd24:   c = 7'h4F;
      7'd25:   c = 7'h50;
      7'd26:   c = 7'h7B;  // {
      7'd27:   c = 7'h7D;  // }
      7'd28:   c = 7'h0A;
      7'd30:   c = 7'h41;  // A
      7'd31:   c = 7'h53;
      7'd32:   c = 7'h44;
      7'd33:   c = 7'h46;
      7'd34:   c = 7'h47;
      7'd35:   c = 7'h48;
      7'd36:   c = 7'h4A;
      7'd37:   c = 7'h4B;
      7'd38:   c = 7'h4C;
      7'd39:   c = 7'h3A;  // :
      7'd40:   c = 7'h22;  // double quote
      7'd41:   c = 7'h7E;  // ~
      7'd43:   c = 7'h7C;  // |
      7'd44:   c = 7'h5A;  // Z
      7'd45:   c = 7'h58;
      7'd46:   c = 7'h43;
      7'd47:   c = 7'h56;
      7'd48:   c = 7'h42;
      7'd49:   c = 7'h4E;
      7'd50:   c = 7'h4D;
      7'd51:   c = 7'h3C;  // <
      7'd52:   c = 7'h3E;  // >
      7'd53:   c = 7'h3F;  // ?
      7'd55:   c = 7'h2A;
      7'd57:   c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/sca_ram.sv @@
// ----------------------------------------------------------------------------
// sca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, hold data when not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sca_key_decode.sv @@
// ----------------------------------------------------------------------------
// sca_key_decode
// Decodes one set 1 scan byte into modifier updates and a character to push.
// ----------------------------------------------------------------------------
module sca_key_decode (
  input  logic         [7:0] scan_byte_i,
  input  logic               shift_held_i,
  input  logic               ctrl_held_i,
  output sca_pkg::key_t      key_o
);
  import sca_pkg::*;

  logic [6:0]        code;
  logic              pressed;
  logic [CHAR_W-1:0] rom_char;
  logic [CHAR_W-1:0] mapped_char;
  logic              is_lower;

  assign code    = scan_byte_i[6:0];
  assign pressed = ~scan_byte_i[7];

  // Look up the layout and fold letters under ctrl
  assign rom_char    = shift_held_i ? rom_shift(code) : rom_plain(code);
  assign is_lower    = (rom_char >= LOWER_A) && (rom_char <= LOWER_Z);
  assign mapped_char = (ctrl_held_i && is_lower) ? rom_char - CTRL_OFFSET : rom_char;

  // Classify the key
  always_comb begin
    key_o          = '0;
    key_o.held     = pressed;
    key_o.key_char = mapped_char;
    if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
      key_o.shift_we = 1'b1;
    end else if (code == KEY_CTRL) begin
      key_o.ctrl_we = 1'b1;
    end else if (code != KEY_ALT && pressed) begin
      key_o.push = (mapped_char != '0);
    end
  end

endmodule

@@ rtl/scancode_to_ascii_fifo.sv @@
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo
// Set 1 keyboard scan code decoder feeding a character FIFO.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries an action and a scan
//   byte. Action scan decodes the byte, tracks shift and ctrl, and pushes a
//   nonzero character; action pop removes one character; action flush
//   empties the FIFO but keeps the modifier state.
//   Output channel (out_valid_o / out_stall_i) returns one result per item:
//   the popped character and its valid flag, whether characters are still
//   waiting, and whether a decoded character was lost to a full FIFO.
//   The FIFO has FIFO_DEPTH slots and holds at most FIFO_DEPTH-1 characters.
//   A result passes through the work stage, where the state update and RAM
//   read take place, and then through the result register.
//   Throughput: one item per cycle unless in_stall_o is high; every action
//   updates the pointers when it is accepted, so items can follow back to back.
//   Reset: pointers and modifier flags clear, the FIFO is empty, and the
//   character RAM is not cleared (only written slots are ever read).
//   Stall: a stalled result holds; the stage behind it fills, and then
//   in_stall_o rises until the result is taken.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 action_i,
  input  logic [7:0]                 scan_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [sca_pkg::CHAR_W-1:0] char_out_o,
  output logic                       char_valid_o,
  output logic                       chars_waiting_o,
  output logic                       dropped_o
);
  import sca_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic              in_accept;
  key_t              key;
  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [PTR_W-1:0]  wp_inc, rp_inc;
  logic              shift_q, shift_d, ctrl_q, ctrl_d;
  logic              ram_we, ram_re;
  logic [CHAR_W-1:0] ram_rdata;
  logic              hit, drop;

  logic              s1_valid_q, s1_valid_d;
  logic              s1_hit_q, s1_wait_q, s1_drop_q;
  logic              s1_adv;

  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_cv_q, out_wait_q, out_drop_q;

  // Handshake
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_adv     = s1_valid_q && !(out_valid_q && out_stall_i);

  sca_key_decode u_decode (
    .scan_byte_i  (scan_byte_i),
    .shift_held_i (shift_q),
    .ctrl_held_i  (ctrl_q),
    .key_o        (key)
  );

  // Ring pointers wrap at the last slot
  assign wp_inc = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
  assign rp_inc = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;

  // Apply the accepted action to the FIFO and modifier state
  always_comb begin
    wp_d    = wp_q;
    rp_d    = rp_q;
    shift_d = shift_q;
    ctrl_d  = ctrl_q;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    hit     = 1'b0;
    drop    = 1'b0;
    if (in_accept) begin
      unique case (action_e'(action_i))
        ACT_SCAN: begin
          if (key.shift_we) shift_d = key.held;
          if (key.ctrl_we)  ctrl_d  = key.held;
          if (key.push) begin
            if (wp_inc == rp_q) begin
              drop = 1'b1;
            end else begin
              ram_we = 1'b1;
              wp_d   = wp_inc;
            end
          end
        end
        ACT_POP: begin
          if (wp_q != rp_q) begin
            ram_re = 1'b1;
            hit    = 1'b1;
            rp_d   = rp_inc;
          end
        end
        ACT_FLUSH: begin
          wp_d = '0;
          rp_d = '0;
        end
        default: ;
      endcase
    end
  end

  sca_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (key.key_char),
    .re_i    (ram_re),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      shift_q <= 1'b0;
      ctrl_q  <= 1'b0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      shift_q <= shift_d;
      ctrl_q  <= ctrl_d;
    end
  end

  // Work stage: flags wait here while the RAM read completes
  assign s1_valid_d = in_accept || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_hit_q  <= hit;
      s1_wait_q <= (wp_d != rp_d);
      s1_drop_q <= drop;
    end
  end

  // Result register: load on advance, drop when taken
  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_char_q <= s1_hit_q ? ram_rdata : '0;
      out_cv_q   <= s1_hit_q;
      out_wait_q <= s1_wait_q;
      out_drop_q <= s1_drop_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign char_out_o      = out_char_q;
  assign char_valid_o    = out_cv_q;
  assign chars_waiting_o = out_wait_q;
  assign dropped_o       = out_drop_q;

endmodule

@@ rtl/sca_checker.sv @@
// ----------------------------------------------------------------------------
// sca_checker
// Port-level checks for the scan code to ASCII FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module sca_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [sca_pkg::CHAR_W-1:0] char_out_o,
  input logic                       char_valid_o,
  input logic                       chars_waiting_o,
  input logic                       dropped_o
);
  import sca_pkg::*;

  // Input backpressure only comes from a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("in_stall_o without a stalled result");

  // Without a valid character, char_out_o reads as zero
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !char_valid_o) |-> (char_out_o == '0))
    else $error("char_out_o nonzero without char_valid_o");

  // A drop means the FIFO was full, so characters remain and nothing was popped
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dropped_o) |-> (chars_waiting_o && !char_valid_o))
    else $error("dropped_o with empty FIFO or with a pop");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(char_out_o) && $stable(char_valid_o)
       && $stable(chars_waiting_o) && $stable(dropped_o)))
    else $error("stalled result changed");

endmodule

bind scancode_to_ascii_fifo sca_checker u_sca_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .char_out_o      (char_out_o),
  .char_valid_o    (char_valid_o),
  .chars_waiting_o (chars_waiting_o),
  .dropped_o       (dropped_o)
);

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scan code to ASCII FIFO. A driver sends scan
// bytes, pops, flushes and no-op actions from a queue of pending items; a
// monitor compares every result against a behavioral copy of the decoder
// (shift and ctrl tracking, US-layout lookup, ring FIFO with drop on full).
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sca_pkg::*;

  // One pending item, or a marker that holds the sender until all results
  // are back
  typedef struct {
    logic        drain;
    action_e     act;
    logic [7:0]  scan;
    int unsigned idle_pct;
    int unsigned stall_pct;
  } keystroke_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              valid;
    logic              waiting;
    logic              drop;
  } char_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [1:0]          action_i    = 2'd0;
  logic [7:0]          scan_byte_i = 8'd0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [CHAR_W-1:0]   char_out_o;
  logic                char_valid_o;
  logic                chars_waiting_o;
  logic                dropped_o;

  keystroke_t          keystroke_q[$];
  char_result_t        result_due_q[$];

  // Behavioral copy of the decoder state
  logic [CHAR_W-1:0]   plain_map [128];
  logic [CHAR_W-1:0]   shifted_map [128];
  logic [CHAR_W-1:0]   ring_mem [64];
  logic [5:0]          ring_wr;
  logic [5:0]          ring_rd;
  logic                shift_on;
  logic                ctrl_on;

  int unsigned         ph_idle;
  int unsigned         ph_stall;
  int unsigned         stall_pct;
  int                  errors;
  int                  n_items;
  int                  n_popped;
  int                  n_dropped;
  int                  n_flush;

  scancode_to_ascii_fifo #(.FIFO_DEPTH(64)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .scan_byte_i    (scan_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .char_out_o     (char_out_o),
    .char_valid_o   (char_valid_o),
    .chars_waiting_o(chars_waiting_o),
    .dropped_o      (dropped_o)
  );

  // Fill both key maps from rows of the US layout
  function automatic void load_key_maps();
    string lo_row [4];
    string hi_row [4];
    int    first [4];
    for (int i = 0; i < 128; i++) begin
      plain_map[i]   = '0;
      shifted_map[i] = '0;
    end
    lo_row[0] = "1234567890-=";  hi_row[0] = "!@#$%^&*()_+";  first[0] = 2;
    lo_row[1] = "qwertyuiop[]";  hi_row[1] = "QWERTYUIOP{}";  first[1] = 16;
    lo_row[2] = "asdfghjkl;'";   hi_row[2] = "ASDFGHJKL:\"~"; first[2] = 30;
    lo_row[3] = "zxcvbnm,./";    hi_row[3] = "ZXCVBNM<>?";    first[3] = 44;
    for (int r = 0; r < 4; r++) begin
      for (int i = 0; i < lo_row[r].len(); i++) begin
        plain_map[first[r] + i] = CHAR_W'(lo_row[r][i]);
      end
      for (int i = 0; i < hi_row[r].len(); i++) begin
        shifted_map[first[r] + i] = CHAR_W'(hi_row[r][i]);
      end
    end
    // Backtick, control keys and keypad entries
    plain_map[41] = 7'h60;
    plain_map[43] = 7'h5C;  shifted_map[43] = 7'h7C;
    plain_map[1]  = 7'h1B;  shifted_map[1]  = 7'h1B;
    plain_map[14] = 7'h08;  shifted_map[14] = 7'h08;
    plain_map[15] = 7'h09;  shifted_map[15] = 7'h09;
    plain_map[28] = 7'h0A;  shifted_map[28] = 7'h0A;
    plain_map[55] = 7'h2A;  shifted_map[55] = 7'h2A;
    plain_map[57] = 7'h20;  shifted_map[57] = 7'h20;
    plain_map[74] = 7'h2D;
    plain_map[78] = 7'h2B;
  endfunction

  // Advance the decoder copy by one item and return its result
  function automatic char_result_t predict_keyboard_step(action_e act, logic [7:0] sb);
    char_result_t      res;
    logic [6:0]        code;
    logic              press;
    logic [CHAR_W-1:0] ch;
    res   = '0;
    code  = sb[6:0];
    press = ~sb[7];
    case (act)
      ACT_SCAN: begin
        if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
          shift_on = press;
        end else if (code == KEY_CTRL) begin
          ctrl_on = press;
        end else if (code != KEY_ALT && press) begin
          ch = shift_on ? shifted_map[code] : plain_map[code];
          if (ctrl_on && ch >= LOWER_A && ch <= LOWER_Z) ch = ch - CTRL_OFFSET;
          if (ch != '0) begin
            // Ring keeps one slot free; drop the character when full
            if (ring_wr + 6'd1 == ring_rd) begin
              res.drop = 1'b1;
            end else begin
              ring_mem[ring_wr] = ch;
              ring_wr           = ring_wr + 6'd1;
            end
          end
        end
      end
      ACT_POP: begin
        if (ring_wr != ring_rd) begin
          res.ch    = ring_mem[ring_rd];
          res.valid = 1'b1;
          ring_rd   = ring_rd + 6'd1;
        end
      end
      ACT_FLUSH: begin
        ring_wr = '0;
        ring_rd = '0;
      end
      default: ;
    endcase
    res.waiting = (ring_wr != ring_rd);
    return res;
  endfunction

  function automatic void queue_item(action_e act, logic [7:0] sb);
    keystroke_t k;
    k.drain     = 1'b0;
    k.act       = act;
    k.scan      = sb;
    k.idle_pct  = ph_idle;
    k.stall_pct = ph_stall;
    keystroke_q.push_back(k);
  endfunction

  function automatic void queue_drain();
    keystroke_t k;
    k.drain     = 1'b1;
    k.act       = ACT_NONE;
    k.scan      = '0;
    k.idle_pct  = ph_idle;
    k.stall_pct = ph_stall;
    keystroke_q.push_back(k);
  endfunction

  // Random key: mostly mapped codes, sometimes anything in the code space
  function automatic logic [6:0] pick_key();
    if ($urandom_range(3) != 0) return 7'($urandom_range(1, 57));
    return 7'($urandom_range(127));
  endfunction

  // Typing: key presses with releases and modifier changes mixed in
  function automatic int add_typing(int presses);
    int         added;
    logic [6:0] k;
    added = 0;
    for (int i = 0; i < presses; i++) begin
      if ($urandom_range(99) < 12) begin
        queue_item(ACT_SCAN, {1'($urandom_range(1)),
                              ($urandom_range(1) != 0) ? KEY_LSHIFT : KEY_RSHIFT});
        added++;
      end
      if ($urandom_range(99) < 7) begin
        queue_item(ACT_SCAN, {1'($urandom_range(1)), KEY_CTRL});
        added++;
      end
      k = pick_key();
      queue_item(ACT_SCAN, {1'b0, k});
      added++;
      if ($urandom_range(1) != 0) begin
        queue_item(ACT_SCAN, {1'b1, k});
        added++;
      end
    end
    return added;
  endfunction

  // Reading: mostly pops, now and then a key press
  function automatic int add_reading(int pops);
    int added;
    added = 0;
    for (int i = 0; i < pops; i++) begin
      if ($urandom_range(99) < 15) begin
        queue_item(ACT_SCAN, {1'b0, pick_key()});
        added++;
      end
      queue_item(ACT_POP, 8'($urandom_range(255)));
      added++;
    end
    return added;
  endfunction

  function automatic int add_noise(int n);
    for (int i = 0; i < n; i++) begin
      queue_item(action_e'($urandom_range(3)), 8'($urandom_range(255)));
    end
    return n;
  endfunction

  function automatic void add_phase(int unsigned idle, int unsigned stall, int count);
    int added;
    int kind;
    ph_idle  = idle;
    ph_stall = stall;
    // Open with a long burst so the ring fills up and overflows
    added = add_typing(90);
    while (added < count) begin
      kind = $urandom_range(9);
      if (kind < 5) begin
        added += add_typing($urandom_range(5, 90));
      end else if (kind < 8) begin
        added += add_reading($urandom_range(5, 70));
      end else begin
        added += add_noise($urandom_range(10, 30));
        if (kind == 9) begin
          queue_item(ACT_FLUSH, 8'($urandom_range(255)));
          added++;
        end
      end
    end
    queue_drain();
  endfunction

  function automatic void add_directed();
    ph_idle  = 0;
    ph_stall = 0;
    queue_item(ACT_SCAN, 8'h00);   // code with no character
    queue_item(ACT_SCAN, 8'h1E);   // a
    queue_item(ACT_SCAN, 8'h9E);   // release of an ordinary key
    queue_item(ACT_SCAN, 8'h2A);   // left shift down
    queue_item(ACT_SCAN, 8'h1E);   // A
    queue_item(ACT_SCAN, 8'h4A);   // keypad minus has no shifted character
    queue_item(ACT_SCAN, 8'hAA);   // left shift up
    queue_item(ACT_SCAN, 8'h36);   // right shift down
    queue_item(ACT_SCAN, 8'h02);   // !
    queue_item(ACT_SCAN, 8'hB6);   // right shift up
    queue_item(ACT_SCAN, 8'h1D);   // ctrl down
    queue_item(ACT_SCAN, 8'h1E);   // ctrl-a
    queue_item(ACT_SCAN, 8'h2C);   // ctrl-z
    queue_item(ACT_SCAN, 8'h2A);   // shift with ctrl
    queue_item(ACT_SCAN, 8'h10);   // uppercase Q passes unchanged
    queue_item(ACT_SCAN, 8'hAA);
    queue_item(ACT_SCAN, 8'h9D);   // ctrl up
    queue_item(ACT_SCAN, 8'h38);   // alt is ignored
    queue_item(ACT_SCAN, 8'h4A);   // keypad minus
    queue_item(ACT_SCAN, 8'h4E);   // keypad plus
    queue_item(ACT_SCAN, 8'h7F);   // top code
    queue_item(ACT_SCAN, 8'hFF);
    queue_item(ACT_POP,  8'h00);
    queue_item(ACT_POP,  8'hFF);
    queue_item(ACT_FLUSH, 8'h5A);  // flush keeps the modifiers
    queue_item(ACT_POP,  8'h00);   // pop from an empty ring
    queue_item(ACT_NONE, 8'hA5);
    queue_drain();
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: present pending items, hold a stalled item, idle at random
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic       accepted;
    logic       present;
    keystroke_t k;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      accepted = in_valid_i && !in_stall_o;
      present  = 1'b0;
      if (accepted) begin
        result_due_q.push_back(predict_keyboard_step(action_e'(action_i), scan_byte_i));
        n_items++;
        if (action_i == ACT_FLUSH) n_flush++;
      end
      if (!in_valid_i || accepted) begin
        if (keystroke_q.size() != 0 && keystroke_q[0].drain &&
            result_due_q.size() == 0) begin
          void'(keystroke_q.pop_front());
        end else if (keystroke_q.size() != 0 && !keystroke_q[0].drain) begin
          stall_pct = keystroke_q[0].stall_pct;
          if ($urandom_range(99) >= keystroke_q[0].idle_pct) begin
            k           = keystroke_q.pop_front();
            present     = 1'b1;
            action_i    <= k.act;
            scan_byte_i <= k.scan;
          end
        end
        in_valid_i <= present;
      end
    end
  end

  // Monitor: check each result against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin : watch
    char_result_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (result_due_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result char=%0h valid=%0b waiting=%0b dropped=%0b",
                   $realtime, char_out_o, char_valid_o, chars_waiting_o, dropped_o);
        end else begin
          e = result_due_q.pop_front();
          if (e.valid) n_popped++;
          else if (e.drop) n_dropped++;
          if (char_out_o !== e.ch) begin
            errors++;
            $display("%0t: char_out expected %0h actual %0h", $realtime, e.ch, char_out_o);
          end
          if (char_valid_o !== e.valid) begin
            errors++;
            $display("%0t: char_valid expected %0b actual %0b",
                     $realtime, e.valid, char_valid_o);
          end
          if (chars_waiting_o !== e.waiting) begin
            errors++;
            $display("%0t: chars_waiting expected %0b actual %0b",
                     $realtime, e.waiting, chars_waiting_o);
          end
          if (dropped_o !== e.drop) begin
            errors++;
            $display("%0t: dropped expected %0b actual %0b", $realtime, e.drop, dropped_o);
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Reset, stimulus, and end of run
  initial begin
    rst_ni    = 1'b0;
    errors    = 0;
    n_items   = 0;
    n_popped  = 0;
    n_dropped = 0;
    n_flush   = 0;
    stall_pct = 0;
    ring_wr   = '0;
    ring_rd   = '0;
    shift_on  = 1'b0;
    ctrl_on   = 1'b0;
    for (int i = 0; i < 64; i++) ring_mem[i] = '0;
    load_key_maps();

    add_directed();
    add_phase(0, 0, 365);
    add_phase(88, 0, 365);
    add_phase(0, 88, 365);
    add_phase(24, 24, 365);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the queue to empty and every result to come back
    while (keystroke_q.size() != 0 || in_valid_i || result_due_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);

    $display("Covered %0d items: %0d characters popped, %0d dropped on a full ring,",
             n_items, n_popped, n_dropped);
    $display("%0d flushes, under four idle and stall mixes.", n_flush);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("tb NOT OK");
    $finish;
  end

endmodule
